// ===== rtl/ts_pkg.sv =====
package ts_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int BANK_XW = XW - 1;
    localparam int BANK_YW = YW - 1;
    localparam int BANK_AW = BANK_XW + BANK_YW;
    localparam int BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int TEXEL_W = 48;
    localparam int COORD_W = 17;
    localparam logic [COORD_W-1:0] COORD_ONE = 17'h10000;
    localparam logic [7:0] DIM_RESET = 8'd128;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;
    localparam logic MODE_NEAREST = 1'b0;
    localparam logic MODE_LINEAR  = 1'b1;
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_texel;

    typedef struct packed {
        logic          is_write;
        logic          linear;
        logic [XW-1:0] x0;
        logic [XW-1:0] x1;
        logic [YW-1:0] y0;
        logic [YW-1:0] y1;
        logic [15:0]   fx;
        logic [15:0]   fy;
        t_texel        data;
    } t_cmd;

endpackage

// ===== rtl/ts_if.sv =====
interface ts_req_if
    import ts_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [6:0]          texel_x;
    logic [6:0]          texel_y;
    logic [15:0]         red_in;
    logic [15:0]         green_in;
    logic [15:0]         blue_in;
    logic [COORD_W-1:0]  coord_u;
    logic [COORD_W-1:0]  coord_v;
    logic                filter_mode;
    modport source (output valid, req_type, texel_x, texel_y, red_in, green_in, blue_in,
                    coord_u, coord_v, filter_mode, input ready);
    modport sink   (input valid, req_type, texel_x, texel_y, red_in, green_in, blue_in,
                    coord_u, coord_v, filter_mode, output ready);
endinterface

interface ts_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface ts_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/texture_sampler.sv =====
// An accepted sample passes the front registers, queue and back pipeline. Throughput:
// one item per cycle, writes and samples alike, if unstalled; four texel banks split
// by the low bits of x and y serve all four neighbours from one read port each.
// Reset: synchronous, active low; clears handshake state and sets width and height
// to 128. The texel store is not cleared and holds garbage until written.
module texture_sampler
    import ts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    ts_req_if.sink   req,
    ts_cfg_if.sink   cfg,
    ts_rsp_if.source rsp
);
    logic f_valid, f_ready, b_valid, b_ready;
    t_cmd f_cmd, b_cmd;

    ts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .cfg(cfg),
        .o_valid(f_valid), .o_cmd(f_cmd), .i_ready(f_ready)
    );

    ts_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .i_cmd(f_cmd), .o_ready(f_ready),
        .o_valid(b_valid), .o_cmd(b_cmd), .i_ready(b_ready)
    );

    ts_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(b_valid), .i_cmd(b_cmd), .o_ready(b_ready), .rsp(rsp)
    );
endmodule

// ===== rtl/ts_ram.sv =====
module ts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/ts_front.sv =====
module ts_front
    import ts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    ts_req_if.sink   req,
    ts_cfg_if.sink   cfg,
    output logic     o_valid,
    output t_cmd     o_cmd,
    input  logic     i_ready
);
    logic [7:0] r_width, r_height;
    logic [XW:0] w_dim;
    logic [YW:0] h_dim;
    logic [COORD_W-1:0] u_c, v_c;
    logic [COORD_W+XW-1:0] r_sx, n_sx;
    logic [COORD_W+YW-1:0] r_sy, n_sy;
    logic [XW:0] r_wm1;
    logic [YW:0] r_hm1;
    logic r_v1, r_wr1, r_lin1;
    t_texel r_d1;
    logic [6:0] r_tx1, r_ty1;
    logic r_v2;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic adv;
    logic [COORD_W+XW-1:0] sxr;
    logic [COORD_W+YW-1:0] syr;
    logic [XW:0] x0e;
    logic [YW:0] y0e;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (cfg.valid) begin
            if (cfg.index == CFG_WIDTH) begin
                r_width <= cfg.data;
            end else begin
                r_height <= cfg.data;
            end
        end
    end

    always_comb begin
        if (r_width == 8'd0) begin
            w_dim = (XW+1)'(1);
        end else if (r_width > 8'(MAX_WIDTH)) begin
            w_dim = (XW+1)'(MAX_WIDTH);
        end else begin
            w_dim = r_width[XW:0];
        end
        if (r_height == 8'd0) begin
            h_dim = (YW+1)'(1);
        end else if (r_height > 8'(MAX_HEIGHT)) begin
            h_dim = (YW+1)'(MAX_HEIGHT);
        end else begin
            h_dim = r_height[YW:0];
        end
        u_c = (req.coord_u > COORD_ONE) ? COORD_ONE : req.coord_u;
        v_c = (req.coord_v > COORD_ONE) ? COORD_ONE : req.coord_v;
        n_sx = (COORD_W+XW)'(u_c * XW'(w_dim - 1'b1));
        n_sy = (COORD_W+YW)'(v_c * YW'(h_dim - 1'b1));
    end

    assign adv = !r_v2 || i_ready;
    assign req.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= req.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_wm1  <= w_dim - 1'b1;
            r_hm1  <= h_dim - 1'b1;
            r_wr1  <= (req.req_type == REQ_WRITE);
            r_lin1 <= (req.filter_mode == MODE_LINEAR);
            r_d1   <= '{req.red_in, req.green_in, req.blue_in};
            r_tx1  <= req.texel_x;
            r_ty1  <= req.texel_y;
            r_cmd  <= n_cmd;
        end
    end

    always_comb begin
        sxr = r_sx + (COORD_W+XW)'(16'h8000);
        syr = r_sy + (COORD_W+YW)'(16'h8000);
        x0e = r_sx[16 +: XW+1];
        y0e = r_sy[16 +: YW+1];
        n_cmd = '0;
        n_cmd.is_write = r_wr1;
        n_cmd.linear   = r_lin1;
        n_cmd.data     = r_d1;
        if (r_wr1) begin
            n_cmd.x0 = XW'(r_tx1);
            n_cmd.y0 = YW'(r_ty1);
        end else if (r_lin1) begin
            n_cmd.x0 = x0e[XW-1:0];
            n_cmd.y0 = y0e[YW-1:0];
            n_cmd.x1 = (x0e < r_wm1) ? XW'(x0e + 1'b1) : r_wm1[XW-1:0];
            n_cmd.y1 = (y0e < r_hm1) ? YW'(y0e + 1'b1) : r_hm1[YW-1:0];
            n_cmd.fx = r_sx[15:0];
            n_cmd.fy = r_sy[15:0];
        end else begin
            n_cmd.x0 = sxr[16 +: XW];
            n_cmd.y0 = syr[16 +: YW];
            n_cmd.x1 = n_cmd.x0;
            n_cmd.y1 = n_cmd.y0;
        end
    end

    assign o_valid = r_v2;
    assign o_cmd   = r_cmd;
endmodule

// ===== rtl/ts_queue.sv =====
module ts_queue
    import ts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_ready
);
    localparam int AW = $clog2(QDEPTH);
    t_cmd r_q [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (AW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
    end
endmodule

// ===== rtl/ts_back.sv =====
module ts_back
    import ts_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_cmd   i_cmd,
    output logic   o_ready,
    ts_rsp_if.source rsp
);
    localparam int NST = 5;
    logic adv, take;
    logic [NST-1:0] r_v;
    logic [XW-1:0] bx [2];
    logic [YW-1:0] by [2];
    logic [BANK_AW-1:0] raddr [4];
    logic [3:0] we;
    logic [BANK_AW-1:0] waddr;
    t_texel rd [4];
    logic r1_sx, r1_sy, r1_lin;
    logic r1_dx, r1_dy;
    logic [15:0] r1_fx, r1_fy;
    t_texel c00, c10, c01, c11;
    logic [31:0] r2_t0 [3], r2_t1 [3], r2_b0 [3], r2_b1 [3];
    logic [32:0] r3_top [3], r3_bot [3];
    logic [15:0] r2_fy, r3_fy;
    logic r2_lin, r3_lin;
    t_texel r2_n, r3_n;
    logic [48:0] r4_a [3], r4_b [3];
    logic r4_lin;
    t_texel r4_n;
    logic [16:0] fxi, fyi;
    logic [49:0] acc [3];
    t_texel r_out;

    assign adv = !r_v[NST-1] || rsp.ready;
    assign o_ready = adv;
    assign take = i_valid && adv && !i_cmd.is_write;

    always_comb begin
        bx[0] = i_cmd.x0;
        bx[1] = i_cmd.x1;
        by[0] = i_cmd.y0;
        by[1] = i_cmd.y1;
        for (int k = 0; k < 4; k++) begin
            logic [XW-1:0] xs;
            logic [YW-1:0] ys;
            xs = bx[0][0] == k[0] ? bx[0] : bx[1];
            ys = by[0][0] == k[1] ? by[0] : by[1];
            raddr[k] = {ys[YW-1:1], xs[XW-1:1]};
        end
        waddr = {i_cmd.y0[YW-1:1], i_cmd.x0[XW-1:1]};
        for (int k = 0; k < 4; k++) begin
            we[k] = i_valid && adv && i_cmd.is_write
                    && i_cmd.x0[0] == k[0] && i_cmd.y0[0] == k[1];
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_bank
        ts_ram #(.WIDTH(TEXEL_W), .DEPTH(BANK_DEPTH)) u_bank (
            .i_clk  (i_clk),
            .i_we   (we[k]),
            .i_waddr(waddr),
            .i_wdata(i_cmd.data),
            .i_re   (adv),
            .i_raddr(raddr[k]),
            .o_rdata(rd[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NST-2:0], take};
        end
    end

    // clamped neighbour shares the bank of its left or upper partner
    always_comb begin
        c00 = rd[{r1_sy, r1_sx}];
        c10 = rd[{r1_sy, r1_sx ^ r1_dx}];
        c01 = rd[{r1_sy ^ r1_dy, r1_sx}];
        c11 = rd[{r1_sy ^ r1_dy, r1_sx ^ r1_dx}];
        fxi = COORD_ONE - 17'(r1_fx);
        fyi = COORD_ONE - 17'(r3_fy);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_sx  <= i_cmd.x0[0];
            r1_sy  <= i_cmd.y0[0];
            r1_dx  <= (i_cmd.x1 != i_cmd.x0);
            r1_dy  <= (i_cmd.y1 != i_cmd.y0);
            r1_lin <= i_cmd.linear;
            r1_fx  <= i_cmd.fx;
            r1_fy  <= i_cmd.fy;

            r2_t0[0] <= 32'(c00.red   * fxi);  r2_t1[0] <= c10.red   * r1_fx;
            r2_t0[1] <= 32'(c00.green * fxi);  r2_t1[1] <= c10.green * r1_fx;
            r2_t0[2] <= 32'(c00.blue  * fxi);  r2_t1[2] <= c10.blue  * r1_fx;
            r2_b0[0] <= 32'(c01.red   * fxi);  r2_b1[0] <= c11.red   * r1_fx;
            r2_b0[1] <= 32'(c01.green * fxi);  r2_b1[1] <= c11.green * r1_fx;
            r2_b0[2] <= 32'(c01.blue  * fxi);  r2_b1[2] <= c11.blue  * r1_fx;
            r2_fy  <= r1_fy;
            r2_lin <= r1_lin;
            r2_n   <= c00;

            for (int c = 0; c < 3; c++) begin
                r3_top[c] <= 33'(r2_t0[c]) + 33'(r2_t1[c]);
                r3_bot[c] <= 33'(r2_b0[c]) + 33'(r2_b1[c]);
                r4_a[c]   <= 49'(r3_top[c] * fyi);
                r4_b[c]   <= 49'(r3_bot[c] * r3_fy);
            end
            r3_fy  <= r2_fy;
            r3_lin <= r2_lin;
            r3_n   <= r2_n;
            r4_lin <= r3_lin;
            r4_n   <= r3_n;

            if (r4_lin) begin
                r_out <= '{acc[0][47:32], acc[1][47:32], acc[2][47:32]};
            end else begin
                r_out <= r4_n;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc[c] = 50'(r4_a[c]) + 50'(r4_b[c]) + 50'h80000000;
        end
    end

    assign rsp.valid     = r_v[NST-1];
    assign rsp.red_out   = r_out.red;
    assign rsp.green_out = r_out.green;
    assign rsp.blue_out  = r_out.blue;
endmodule
